// ----- design/gphm_pkg.sv -----
// Shared types, codes and constants of the group-probed hash map.
package gphm_pkg;

   // Default sizing handed to the top-level parameters
   localparam int DEF_CAPACITY    = 1024;
   localparam int DEF_GROUP_SIZE  = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   // Mixer constants and slot markers
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam int          MIX_SHIFT_A = 30;
   localparam int          MIX_SHIFT_B = 27;
   localparam int          MIX_SHIFT_C = 31;
   localparam logic [7:0]  TAG_EMPTY   = 8'h80;
   localparam int          TAG_BITS    = 7;

   // Hash sequencer schedule (mix counter values)
   localparam logic [3:0] MIX_LOAD_A  = 4'd0;
   localparam logic [3:0] MIX_LOAD_B  = 4'd5;
   localparam logic [3:0] MIX_FINISH  = 4'd10;
   localparam logic [3:0] MIX_PROBE   = 4'd11;

   // Operation codes; unused codes act as a lookup
   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_SET    = 3'd1,
      OP_ACCUM  = 3'd2,
      OP_KEEPMIN = 3'd3,
      OP_FETCH  = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   // Partial-product selection of the 64-bit multiply
   typedef enum logic [1:0] {
      MUL_LO_LO = 2'd0,
      MUL_LO_HI = 2'd1,
      MUL_HI_LO = 2'd2
   } mul_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        latch_req;
      logic        mix_load;
      logic        mix_mid;
      logic        second;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        hash_fin;
      logic        probe_start;
      logic        probe_run;
      logic        update;
      logic        clr_start;
      logic        clr_step;
      logic        clr_rsp;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic probe_done;
      logic clr_last;
   } sts_type;

endpackage

// ----- design/gphm_ctrl.sv -----
// Controller state machine of the group-probed hash map.
module gphm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_operation,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gphm_pkg::sts_type sts,
   output gphm_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_MIX    = 6'b000100,
      ST_PROBE  = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] mix_cnt_ff, mix_cnt_in;
   logic       clr_pend_ff, clr_pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       rsp_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one transaction
   always_comb begin
      state_in    = state_ff;
      mix_cnt_in  = mix_cnt_ff;
      clr_pend_in = clr_pend_ff;
      rsp_load    = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               if (req_operation == gphm_pkg::OP_CLEAR) begin
                  cmd.clr_start = 1'b1;
                  clr_pend_in   = 1'b1;
                  state_in      = ST_CLEAR;
               end else begin
                  mix_cnt_in = '0;
                  state_in   = ST_MIX;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = clr_pend_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_MIX: begin
            // two multiplies, each as three partial products through one unit
            mix_cnt_in   = mix_cnt_ff + 4'd1;
            cmd.mix_load = (mix_cnt_ff == gphm_pkg::MIX_LOAD_A);
            cmd.mix_mid  = (mix_cnt_ff == gphm_pkg::MIX_LOAD_B);
            cmd.second   = (mix_cnt_ff > gphm_pkg::MIX_LOAD_B);
            cmd.hash_fin = (mix_cnt_ff == gphm_pkg::MIX_FINISH);
            if (mix_cnt_ff != gphm_pkg::MIX_LOAD_A && mix_cnt_ff < gphm_pkg::MIX_FINISH &&
                mix_cnt_ff != gphm_pkg::MIX_LOAD_B) begin
               unique case (mix_cnt_ff)
                  4'd1, 4'd6: begin
                     cmd.mul_go  = 1'b1;
                     cmd.mul_sel = gphm_pkg::MUL_LO_LO;
                  end
                  4'd2, 4'd7: begin
                     cmd.mul_go   = 1'b1;
                     cmd.mul_sel  = gphm_pkg::MUL_LO_HI;
                     cmd.acc_load = 1'b1;
                  end
                  4'd3, 4'd8: begin
                     cmd.mul_go  = 1'b1;
                     cmd.mul_sel = gphm_pkg::MUL_HI_LO;
                     cmd.acc_add = 1'b1;
                  end
                  default: begin
                     cmd.acc_add = 1'b1;
                  end
               endcase
            end
            if (mix_cnt_ff == gphm_pkg::MIX_PROBE) begin
               cmd.probe_start = 1'b1;
               state_in        = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.probe_run = 1'b1;
            if (sts.probe_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.update = 1'b1;
               rsp_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.clr_rsp = 1'b1;
               rsp_load    = 1'b1;
               clr_pend_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until it is taken
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mix_cnt_ff   <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mix_cnt_ff   <= mix_cnt_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/gphm_dp.sv -----
// Datapath of the group-probed hash map: mixer, slot stores, probe and update.
module gphm_dp #(
   parameter int CAPACITY    = gphm_pkg::DEF_CAPACITY,
   parameter int GROUP_SIZE  = gphm_pkg::DEF_GROUP_SIZE,
   parameter int VALUE_WIDTH = gphm_pkg::DEF_VALUE_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gphm_pkg::cmd_type        cmd,
   output gphm_pkg::sts_type        sts,
   input  logic [2:0]               req_operation,
   input  logic [63:0]              req_key,
   input  logic signed [31:0]       req_value,
   input  logic                     csr_wr_en,
   input  logic [63:0]              csr_wr_data,
   output logic                     rsp_found,
   output logic signed [31:0]       rsp_result_value,
   output logic [9:0]               rsp_slot,
   output logic                     rsp_status,
   output logic [9:0]               rsp_entry_count,
   output logic                     rsp_improved
);

   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int GIDX_W     = $clog2(GROUP_SIZE);
   localparam int MAX_GROUPS = CAPACITY / GROUP_SIZE + 1;
   localparam int GCNT_W     = $clog2(MAX_GROUPS);
   localparam int LOAD_LIMIT = CAPACITY / 2;
   localparam int CNT_W      = $clog2(LOAD_LIMIT + 1);

   // Request and configuration registers
   logic [2:0]                    op_ff;
   logic [63:0]                   key_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic [63:0]                   seed_ff;

   // Mixer registers
   logic [63:0] opd_ff, prod_ff, acc_ff, mix_x, mul_c;
   logic [31:0] mul_a, mul_b;
   logic [7:0]  tag_ff;
   logic [SLOT_W-1:0] home_ff;

   // Slot stores
   logic [7:0]             tag_mem [CAPACITY];
   logic [63:0]            key_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
   logic [7:0]             tag_rd_ff;
   logic [63:0]            key_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;

   // Probe registers
   logic [SLOT_W-1:0] base_ff, rd_addr, pipe_slot_ff, empty_slot_ff, slot_ff;
   logic [GIDX_W-1:0] idx_ff;
   logic [GCNT_W-1:0] grp_ff;
   logic              issuing_ff, pipe_vld_ff, pipe_last_ff, empty_seen_ff;
   logic              hit_ff, none_ff;
   logic signed [VALUE_WIDTH-1:0] cur_ff;
   logic              issue_act, cmp_hit, cmp_empty, grp_empty, grp_end, last_grp, done;
   logic [SLOT_W-1:0] first_empty;

   // Count and clearing sweep
   logic [CNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0] clr_addr_ff;

   // Update logic
   logic                          is_lookup, insert_ok, refused, improved;
   logic signed [VALUE_WIDTH-1:0] new_val, res_val;
   logic [CNT_W-1:0]              count_next;
   logic                          tag_we, key_we, val_we;
   logic [SLOT_W-1:0]             tag_wa;
   logic [7:0]                    tag_wd;

   // Capture the transaction and the seed
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
      if (cmd.latch_req) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         val_ff <= VALUE_WIDTH'(req_value);
      end
   end

   // Mixer: one 32x32 multiplier, product registered, accumulated next cycle
   assign mix_x = key_ff ^ seed_ff;
   assign mul_c = cmd.second ? gphm_pkg::MIX_MUL_B : gphm_pkg::MIX_MUL_A;

   always_comb begin
      unique case (cmd.mul_sel)
         gphm_pkg::MUL_LO_LO: begin
            mul_a = opd_ff[31:0];
            mul_b = mul_c[31:0];
         end
         gphm_pkg::MUL_LO_HI: begin
            mul_a = opd_ff[31:0];
            mul_b = mul_c[63:32];
         end
         default: begin
            mul_a = opd_ff[63:32];
            mul_b = mul_c[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_load) begin
         opd_ff <= mix_x ^ (mix_x >> gphm_pkg::MIX_SHIFT_A);
      end else if (cmd.mix_mid) begin
         opd_ff <= acc_ff ^ (acc_ff >> gphm_pkg::MIX_SHIFT_B);
      end
      if (cmd.mul_go) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff[63:32] <= acc_ff[63:32] + prod_ff[31:0];
      end
      if (cmd.hash_fin) begin
         tag_ff  <= {1'b0, acc_ff[gphm_pkg::TAG_BITS-1:0]
                          ^ acc_ff[gphm_pkg::MIX_SHIFT_C +: gphm_pkg::TAG_BITS]};
         home_ff <= SLOT_W'((acc_ff ^ (acc_ff >> gphm_pkg::MIX_SHIFT_C))
                            >> gphm_pkg::TAG_BITS);
      end
   end

   // Probe compare on the registered read data
   assign rd_addr     = base_ff + SLOT_W'(idx_ff);
   assign issue_act   = cmd.probe_run && issuing_ff;
   assign cmp_hit     = pipe_vld_ff && (tag_rd_ff == tag_ff) && (key_rd_ff == key_ff);
   assign cmp_empty   = pipe_vld_ff && (tag_rd_ff == gphm_pkg::TAG_EMPTY);
   assign grp_empty   = empty_seen_ff || cmp_empty;
   assign grp_end     = pipe_vld_ff && pipe_last_ff && !cmp_hit;
   assign last_grp    = (grp_ff == GCNT_W'(MAX_GROUPS - 1));
   assign done        = cmd.probe_run && (cmp_hit || (grp_end && (grp_empty || last_grp)));
   assign first_empty = empty_seen_ff ? empty_slot_ff : pipe_slot_ff;
   assign sts.probe_done = done;
   assign sts.clr_last   = (clr_addr_ff == SLOT_W'(CAPACITY - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff    <= 1'b0;
         pipe_vld_ff   <= 1'b0;
         empty_seen_ff <= 1'b0;
      end else if (cmd.probe_start) begin
         issuing_ff    <= 1'b1;
         pipe_vld_ff   <= 1'b0;
         empty_seen_ff <= 1'b0;
      end else if (cmd.probe_run) begin
         pipe_vld_ff <= issue_act;
         if (issue_act && idx_ff == GIDX_W'(GROUP_SIZE - 1)) begin
            issuing_ff <= 1'b0;
         end
         if (grp_end && !done) begin
            issuing_ff    <= 1'b1;
            empty_seen_ff <= 1'b0;
         end else if (cmp_empty && !empty_seen_ff) begin
            empty_seen_ff <= 1'b1;
         end
      end
   end

   // Advance the issue index and group
   always_ff @(posedge clock) begin
      if (cmd.probe_start) begin
         base_ff <= home_ff;
         idx_ff  <= '0;
         grp_ff  <= '0;
      end else if (cmd.probe_run) begin
         pipe_slot_ff <= rd_addr;
         pipe_last_ff <= (idx_ff == GIDX_W'(GROUP_SIZE - 1));
         if (issue_act && idx_ff != GIDX_W'(GROUP_SIZE - 1)) begin
            idx_ff <= idx_ff + GIDX_W'(1);
         end
         if (cmp_empty && !empty_seen_ff) begin
            empty_slot_ff <= pipe_slot_ff;
         end
         if (grp_end && !done) begin
            base_ff <= base_ff + SLOT_W'(GROUP_SIZE);
            idx_ff  <= '0;
            grp_ff  <= grp_ff + GCNT_W'(1);
         end
      end
      if (done) begin
         hit_ff  <= cmp_hit;
         none_ff <= !cmp_hit && !grp_empty;
         slot_ff <= cmp_hit ? pipe_slot_ff : (grp_empty ? first_empty : home_ff);
         cur_ff  <= val_rd_ff;
      end
   end

   // Work out the new value and the outcome
   always_comb begin
      is_lookup = !(op_ff == gphm_pkg::OP_SET || op_ff == gphm_pkg::OP_ACCUM ||
                    op_ff == gphm_pkg::OP_KEEPMIN || op_ff == gphm_pkg::OP_FETCH);
      improved  = 1'b0;
      unique case (op_ff)
         gphm_pkg::OP_SET:   new_val = val_ff;
         gphm_pkg::OP_ACCUM: new_val = cur_ff + val_ff;
         gphm_pkg::OP_KEEPMIN: begin
            improved = (val_ff < cur_ff);
            new_val  = improved ? val_ff : cur_ff;
         end
         default:            new_val = cur_ff;
      endcase
      insert_ok = !hit_ff && !is_lookup && !none_ff && (count_ff < CNT_W'(LOAD_LIMIT));
      refused   = !hit_ff && !is_lookup && !insert_ok;
      if (hit_ff) begin
         res_val = new_val;
      end else if (is_lookup) begin
         res_val = val_ff;
      end else if (insert_ok && op_ff != gphm_pkg::OP_FETCH) begin
         res_val = val_ff;
      end else begin
         res_val = '0;
      end
      count_next = count_ff + CNT_W'(insert_ok);
   end

   // Store write ports: clearing sweep or commit
   assign tag_we = cmd.clr_step || (cmd.update && insert_ok);
   assign tag_wa = cmd.clr_step ? clr_addr_ff : slot_ff;
   assign tag_wd = cmd.clr_step ? gphm_pkg::TAG_EMPTY : tag_ff;
   assign key_we = cmd.update && insert_ok;
   assign val_we = cmd.update && (hit_ff || insert_ok);

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[slot_ff] <= key_ff;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[slot_ff] <= res_val;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

   // Track the key count and sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.clr_start) begin
            count_ff    <= '0;
            clr_addr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         end
         if (cmd.update) begin
            count_ff <= count_next;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_found        <= hit_ff;
         rsp_result_value <= 32'(res_val);
         rsp_slot         <= 10'(slot_ff);
         rsp_status       <= refused;
         rsp_entry_count  <= 10'(count_next);
         rsp_improved     <= hit_ff && improved;
      end else if (cmd.clr_rsp) begin
         rsp_found        <= 1'b0;
         rsp_result_value <= '0;
         rsp_slot         <= '0;
         rsp_status       <= 1'b0;
         rsp_entry_count  <= '0;
         rsp_improved     <= 1'b0;
      end
   end

endmodule

// ----- design/group_probed_hash_map_core.sv -----
// Top level of the group-probed hash map: controller, datapath and checks.
//
// Map from 64-bit keys to signed values held in CAPACITY slots. A key is
// XORed with the seed register and mixed with the splitmix64 finalizer; the
// low 7 bits form the tag, the bits above them the home slot. Probing reads
// one slot per cycle through the single read port of the tag, key and value
// stores, in groups of GROUP_SIZE slots. A transaction first hashes the key
// (two 64-bit multiplies as three partial products each on one 32x32
// multiplier), then probes group by group (stopping early when the key is
// found in a group), then commits and loads the result. A clear, and the
// sweep after reset, write one tag per cycle over all CAPACITY slots; no
// transaction is accepted during the sweep. A waiting result does not keep
// the next transaction from being accepted.
module group_probed_hash_map_core #(
   parameter int CAPACITY    = gphm_pkg::DEF_CAPACITY,
   parameter int GROUP_SIZE  = gphm_pkg::DEF_GROUP_SIZE,
   parameter int VALUE_WIDTH = gphm_pkg::DEF_VALUE_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [63:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [63:0]        req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic signed [31:0] rsp_result_value,
   output logic [9:0]         rsp_slot,
   output logic               rsp_status,
   output logic [9:0]         rsp_entry_count,
   output logic               rsp_improved
);

   gphm_pkg::cmd_type cmd;
   gphm_pkg::sts_type sts;

   gphm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   gphm_dp #(
      .CAPACITY    (CAPACITY),
      .GROUP_SIZE  (GROUP_SIZE),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_value        (req_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_found        (rsp_found),
      .rsp_result_value (rsp_result_value),
      .rsp_slot         (rsp_slot),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_improved     (rsp_improved)
   );

   // Busy right after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a transaction without going busy");

   // A refused insert never reports a hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_found)
      else $error("refused insert reported as found");

   // Lowering a value needs an existing key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_improved) |-> rsp_found)
      else $error("improved set without a hit");

   // Count stays within the load limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= 10'(CAPACITY / 2)))
      else $error("entry count beyond load limit");

endmodule

// ----- tb/sv/tb_group_probed_hash_map_core.sv -----
// Testbench for group_probed_hash_map_core: random map traffic checked by a scoreboard.
`timescale 1ns / 1ps

module tb_group_probed_hash_map_core;

   localparam int SLOTS      = 1024;
   localparam int GROUP      = 16;
   localparam int LOAD_LIMIT = SLOTS / 2;
   localparam int POOL_SIZE  = 48;

   // One predicted map response
   typedef struct {
      logic        found;
      logic [31:0] result_value;
      logic [9:0]  slot;
      logic        status;
      logic [9:0]  entry_count;
      logic        improved;
   } map_rsp_type;

   // Shadow copy of the map plus the queue of pending responses
   class map_scoreboard;
      logic [7:0]  tag_mem[SLOTS];
      logic [63:0] key_mem[SLOTS];
      logic [31:0] val_mem[SLOTS];
      int          held;
      logic [63:0] seed;
      map_rsp_type pending[$];
      int          mismatches;

      function new();
         foreach (tag_mem[i]) begin
            tag_mem[i] = gphm_pkg::TAG_EMPTY;
            key_mem[i] = '0;
            val_mem[i] = '0;
         end
         held = 0;
         seed = '0;
         mismatches = 0;
      endfunction

      function logic [63:0] mix_key(logic [63:0] k);
         logic [63:0] x;
         x = k ^ seed;
         x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
         x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
         return x ^ (x >> 31);
      endfunction

      // Predict the response of one accepted request and update the shadow map
      function void note_request(logic [2:0] op, logic [63:0] key, logic [31:0] value);
         map_rsp_type r;
         logic [63:0] h;
         logic [7:0]  tag;
         int          home, base, s, hit, slot;
         logic [31:0] cur, nv;
         r = '{1'b0, 32'd0, 10'd0, 1'b0, 10'd0, 1'b0};
         if (op == gphm_pkg::OP_CLEAR) begin
            foreach (tag_mem[i]) tag_mem[i] = gphm_pkg::TAG_EMPTY;
            held = 0;
         end else begin
            h = mix_key(key);
            tag = {1'b0, h[6:0]};
            home = int'(h[16:7]);
            base = home;
            hit = -1;
            slot = home;
            // probe group by group: confirmed tag hit first, else first empty slot
            for (int g = 0; g < SLOTS / GROUP + 1 && hit < 0; g++) begin
               for (int i = 0; i < GROUP && hit < 0; i++) begin
                  s = (base + i) % SLOTS;
                  if (tag_mem[s] == tag && key_mem[s] == key) begin
                     hit = 1;
                     slot = s;
                  end
               end
               for (int i = 0; i < GROUP && hit < 0; i++) begin
                  s = (base + i) % SLOTS;
                  if (tag_mem[s] == gphm_pkg::TAG_EMPTY) begin
                     hit = 0;
                     slot = s;
                  end
               end
               base = (base + GROUP) % SLOTS;
            end
            if (hit < 0) slot = home;
            r.slot = slot[9:0];
            if (hit == 1) begin
               cur = val_mem[slot];
               r.found = 1'b1;
               if (op == gphm_pkg::OP_SET) cur = value;
               else if (op == gphm_pkg::OP_ACCUM) cur = cur + value;
               else if (op == gphm_pkg::OP_KEEPMIN && $signed(value) < $signed(cur)) begin
                  cur = value;
                  r.improved = 1'b1;
               end
               val_mem[slot] = cur;
               r.result_value = cur;
            end else if (op == gphm_pkg::OP_LOOKUP || op > gphm_pkg::OP_CLEAR) begin
               r.result_value = value;
            end else if (hit < 0 || held >= LOAD_LIMIT) begin
               r.status = 1'b1;
            end else begin
               nv = (op == gphm_pkg::OP_FETCH) ? 32'd0 : value;
               tag_mem[slot] = tag;
               key_mem[slot] = key;
               val_mem[slot] = nv;
               held++;
               r.result_value = nv;
            end
         end
         r.entry_count = held[9:0];
         pending.push_back(r);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(map_rsp_type got);
         map_rsp_type exp_r;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: slot %0d", got.slot);
            return;
         end
         exp_r = pending.pop_front();
         if (got.found !== exp_r.found || got.result_value !== exp_r.result_value ||
             got.slot !== exp_r.slot || got.status !== exp_r.status ||
             got.entry_count !== exp_r.entry_count || got.improved !== exp_r.improved) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp f=%b v=%h s=%0d st=%b n=%0d i=%b",
                        exp_r.found, exp_r.result_value, exp_r.slot, exp_r.status,
                        exp_r.entry_count, exp_r.improved,
                        " got f=%b v=%h s=%0d st=%b n=%0d i=%b",
                        got.found, got.result_value,
                        got.slot, got.status, got.entry_count, got.improved);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [63:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_operation = '0;
   logic [63:0]        req_key = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_found;
   logic signed [31:0] rsp_result_value;
   logic [9:0]         rsp_slot;
   logic               rsp_status;
   logic [9:0]         rsp_entry_count;
   logic               rsp_improved;

   map_scoreboard sb = new();
   logic [63:0]   key_pool[POOL_SIZE];
   bit            quiet = 1'b0;
   bit            hold_req = 1'b0;

   group_probed_hash_map_core u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_result_value(rsp_result_value), .rsp_slot(rsp_slot), .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count), .rsp_improved(rsp_improved)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop for a hung run
   initial begin
      #200_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Check every accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_found, rsp_result_value, rsp_slot, rsp_status,
                             rsp_entry_count, rsp_improved});
   end

   // Drive the response stall: random bursts, one long hold-off on request
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall = 1'b1;
            for (hold = 0; hold < 400; hold++) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_req(logic [2:0] op, logic [63:0] key, logic [31:0] value);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_key = key;
      req_value = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, key, value);
      @(negedge clock);
   endtask

   // Drain all pending responses, then write the seed
   task automatic set_seed(logic [63:0] s);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = s;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.seed = s;
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // Mostly pool keys so operations hit existing entries
   task automatic random_op(int new_key_pct);
      logic [2:0]  op;
      logic [63:0] key;
      if ($urandom_range(0, 99) < new_key_pct) key = rand_key();
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      op = 3'($urandom_range(0, 7));
      if (op == gphm_pkg::OP_CLEAR && $urandom_range(0, 9) != 0) op = gphm_pkg::OP_SET;
      send_req(op, key, $urandom);
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = rand_key();
      key_pool[0] = 64'd0;
      key_pool[1] = '1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of key and value, every operation, wrap and clear
      set_seed(64'd0);
      send_req(gphm_pkg::OP_LOOKUP, 64'd0, 32'h7fffffff);
      send_req(gphm_pkg::OP_SET, 64'd0, 32'h80000000);
      send_req(gphm_pkg::OP_SET, '1, 32'h7fffffff);
      send_req(gphm_pkg::OP_LOOKUP, '1, 32'd5);
      send_req(gphm_pkg::OP_ACCUM, '1, 32'd1);
      send_req(gphm_pkg::OP_ACCUM, 64'd0, 32'hffffffff);
      send_req(gphm_pkg::OP_KEEPMIN, 64'd0, 32'd3);
      send_req(gphm_pkg::OP_KEEPMIN, 64'd0, 32'h80000000);
      send_req(gphm_pkg::OP_KEEPMIN, 64'd0, 32'h80000000);
      send_req(gphm_pkg::OP_KEEPMIN, 64'h1234, 32'd9);
      send_req(gphm_pkg::OP_FETCH, 64'h5678, 32'd77);
      send_req(gphm_pkg::OP_FETCH, 64'h5678, 32'd11);
      send_req(gphm_pkg::OP_ACCUM, 64'h9abc, 32'h80000000);
      send_req(3'd6, 64'h5678, 32'd1);
      send_req(3'd7, 64'hdead, 32'h55555555);
      send_req(gphm_pkg::OP_CLEAR, 64'd0, 32'd0);
      send_req(gphm_pkg::OP_LOOKUP, 64'd0, 32'hffffffff);
      send_req(gphm_pkg::OP_SET, 64'h5678, 32'd2);

      // Fill to the load limit and beyond; long response hold-off early on
      set_seed('1);
      hold_req = 1'b1;
      for (int n = 0; n < 560; n++) begin
         if ($urandom_range(0, 4) == 0) random_op(0);
         else send_req(3'($urandom_range(1, 4)), rand_key(), $urandom);
      end

      // Mixed traffic with a random seed, quiet at the end
      set_seed(rand_key());
      send_req(gphm_pkg::OP_CLEAR, 64'd0, 32'd0);
      for (int n = 0; n < 260; n++) begin
         if (n == 200) quiet = 1'b1;
         random_op(15);
      end
      req_valid = 1'b0;

      for (int w = 0; w < 200000 && sb.pending.size() != 0; w++) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
